// ===== sv/dovt_pkg.sv =====
// Package for the diagonal offset vote tracker: sizes, types and the
// offset binning function. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dovt_pkg;
  localparam int TxBits    = 16;
  localparam int NumTx     = 1 << TxBits;
  localparam int Slots     = 4;
  localparam int SlotBits  = $clog2(Slots);
  localparam int CountBits = 16;
  localparam int OffBits   = 26;
  localparam int EpochBits = 16;
  localparam logic [CountBits-1:0] CntMax = '1;

  // action field codes
  localparam logic ActNewRead = 1'b0;
  localparam logic ActHit     = 1'b1;

  typedef struct packed {
    logic [1:0]           side;
    logic [CountBits-1:0] count;
    logic                 used;
    logic [OffBits-1:0]   offset;
  } slot_t;

  typedef struct packed {
    logic [EpochBits-1:0] epoch;
    logic [CountBits-1:0] best;
    logic [CountBits-1:0] second;
    logic [OffBits-1:0]   best_off;
    slot_t [Slots-1:0]    slots;
  } entry_t;

  typedef enum logic [1:0] {ST_RUN, ST_CLEAR} state_t;

  function automatic logic [OffBits-1:0] bin_offset(input logic [23:0] tp,
      input logic [19:0] sp, input logic [4:0] sh);
    logic signed [25:0] d;
    logic signed [25:0] q;
    d = $signed({2'b00, tp}) - $signed({6'b0, sp});
    q = d >>> sh;
    return q;
  endfunction
endpackage
`default_nettype wire

// ===== sv/dovt_if.sv =====
// Valid/ready channel interfaces for the vote tracker.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface dovt_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] transcript_id;
  logic [23:0] target_position;
  logic [19:0] seed_position;
  logic [1:0]  side_flags;
  modport source(output valid, action, transcript_id, target_position, seed_position,
                 side_flags, input ready);
  modport sink(input valid, action, transcript_id, target_position, seed_position,
               side_flags, output ready);
endinterface

interface dovt_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] hit_votes;
  logic [15:0] top_votes;
  logic [15:0] best_transcript;
  logic        best_valid;
  logic [15:0] runner_votes;
  logic        any_hit;
  modport source(output valid, hit_votes, top_votes, best_transcript, best_valid,
                 runner_votes, any_hit, input ready);
  modport sink(input valid, hit_votes, top_votes, best_transcript, best_valid,
               runner_votes, any_hit, output ready);
endinterface
`default_nettype wire

// ===== sv/dovt_ram.sv =====
// Transcript store: one entry per transcript, registered read.
// Depends on dovt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dovt_ram import dovt_pkg::*; (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [TxBits-1:0] waddr,
  input  wire entry_t            wdata,
  input  wire logic [TxBits-1:0] raddr,
  output entry_t                 rdata
);
  entry_t mem [NumTx];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== sv/diagonal_offset_vote_tracker_top.sv =====
// Top level of the diagonal offset vote tracker: control, voting and summary.
// Depends on dovt_pkg, dovt_if and dovt_ram.
`timescale 1ns / 1ps
`default_nettype none
// A hit reads the transcript entry from the store at its accepting edge; the
// registered read data is then voted on, the entry written back and the
// result registered. A new-read action completes at its accepting edge. The
// next transaction is taken once the previous result leaves, at the earliest at
// the same edge.
// After reset, and when the 16-bit read epoch wraps, a clearing pass writes
// all 65536 entries, one a cycle, before items are taken again.
module diagonal_offset_vote_tracker_top import dovt_pkg::*; (
  input wire logic  clk,
  input wire logic  rst,
  input wire logic  cfg_we,
  input wire logic [4:0] cfg_wdata,
  dovt_in_if.sink   in_ch,
  dovt_out_if.source out_ch
);
  state_t state, state_next;
  logic [4:0] shift;
  logic [EpochBits-1:0] epoch;
  logic [TxBits-1:0] clr_addr;
  logic busy;
  logic [TxBits-1:0] h_tid;
  logic [OffBits-1:0] h_off;
  logic [1:0] h_side;
  logic [CountBits-1:0] g_best, g_runner;
  logic [TxBits-1:0] g_tx;
  logic g_valid, any_hit;
  entry_t rd, wr, e;
  logic we;
  logic [TxBits-1:0] waddr;

  logic accept;
  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == ST_RUN) && !busy && (!out_ch.valid || out_ch.ready);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_RUN:   if (accept && in_ch.action == ActNewRead && epoch == '1) state_next = ST_CLEAR;
      ST_CLEAR: if (clr_addr == '1) state_next = ST_RUN;
      default:  state_next = ST_RUN;
    endcase
  end

  // vote logic on the entry read back
  logic [CountBits-1:0] votes;
  logic hit_found;
  logic free_found;
  logic [SlotBits-1:0] pick;
  always_comb begin
    e = rd;
    if (rd.epoch != epoch) begin
      e = '0;
      e.epoch = epoch;
    end
    wr = e;
    hit_found = 1'b0;
    free_found = 1'b0;
    votes = '0;
    pick = '0;
    for (int i = 0; i < Slots; i++) begin
      if (!hit_found && e.slots[i].used && e.slots[i].offset == h_off) begin
        hit_found = 1'b1;
        wr.slots[i].count = (e.slots[i].count == CntMax) ? CntMax : e.slots[i].count + 1'b1;
        wr.slots[i].side = e.slots[i].side | h_side;
        votes = wr.slots[i].count;
      end
    end
    if (!hit_found) begin
      for (int i = 0; i < Slots; i++) begin
        if (!free_found && !e.slots[i].used) begin
          free_found = 1'b1;
          pick = SlotBits'(i);
        end
      end
      if (!free_found) begin
        for (int i = 1; i < Slots; i++)
          if (e.slots[i].count < e.slots[pick].count) pick = SlotBits'(i);
      end
      wr.slots[pick].used = 1'b1;
      wr.slots[pick].offset = h_off;
      wr.slots[pick].count = CountBits'(1);
      wr.slots[pick].side = h_side;
      votes = CountBits'(1);
    end
    if (votes >= e.best) begin
      if (h_off != e.best_off) wr.second = e.best;
      wr.best = votes;
      wr.best_off = h_off;
    end else if (votes > e.second) begin
      wr.second = votes;
    end
  end

  always_comb begin
    we = 1'b0;
    waddr = h_tid;
    if (state == ST_CLEAR) begin
      we = 1'b1;
      waddr = clr_addr;
    end else if (busy) begin
      we = 1'b1;
    end
  end

  dovt_ram u_ram (.clk(clk), .we(we), .waddr(waddr),
                  .wdata(state == ST_CLEAR ? entry_t'('0) : wr),
                  .raddr(in_ch.transcript_id), .rdata(rd));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      shift <= 5'd5;
      epoch <= EpochBits'(1);
      clr_addr <= '0;
      busy <= 1'b0;
      out_ch.valid <= 1'b0;
      g_best <= '0; g_runner <= '0; g_tx <= '0; g_valid <= 1'b0; any_hit <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) shift <= cfg_wdata;
      if (state == ST_CLEAR) clr_addr <= clr_addr + 1'b1;
      busy <= accept && (in_ch.action == ActHit);
      // hold an unaccepted result, raise one for a new read or a finished hit
      out_ch.valid <= busy || (accept && in_ch.action == ActNewRead) ||
                      (out_ch.valid && !out_ch.ready);
      if (accept) begin
        h_tid <= in_ch.transcript_id;
        h_off <= bin_offset(in_ch.target_position, in_ch.seed_position, shift);
        h_side <= in_ch.side_flags;
        if (in_ch.action == ActNewRead) begin
          epoch <= (epoch == '1) ? EpochBits'(1) : epoch + 1'b1;
          g_best <= '0; g_runner <= '0; g_tx <= '0; g_valid <= 1'b0; any_hit <= 1'b0;
          out_ch.hit_votes <= '0; out_ch.top_votes <= '0; out_ch.best_transcript <= '0;
          out_ch.best_valid <= 1'b0; out_ch.runner_votes <= '0; out_ch.any_hit <= 1'b0;
        end
      end
      if (busy) begin
        out_ch.hit_votes <= votes;
        out_ch.any_hit <= 1'b1;
        any_hit <= 1'b1;
        if (wr.best == votes && votes > g_best) begin
          g_best <= votes; g_tx <= h_tid; g_valid <= 1'b1; g_runner <= wr.second;
          out_ch.top_votes <= votes; out_ch.best_transcript <= h_tid;
          out_ch.best_valid <= 1'b1; out_ch.runner_votes <= wr.second;
        end else begin
          if (wr.best == votes && g_valid && h_tid == g_tx) begin
            g_runner <= wr.second;
            out_ch.runner_votes <= wr.second;
          end else out_ch.runner_votes <= g_runner;
          out_ch.top_votes <= g_best;
          out_ch.best_transcript <= g_valid ? g_tx : '0;
          out_ch.best_valid <= g_valid;
        end
      end
    end
  end

  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !in_ch.ready) else $error("accept during clear");
  a_busy_result: assert property (@(posedge clk) disable iff (rst)
    busy |=> out_ch.valid) else $error("hit without result");
  a_epoch_nonzero: assert property (@(posedge clk) disable iff (rst)
    epoch != '0) else $error("epoch zero");
endmodule
`default_nettype wire

// ===== test/diagonal_offset_vote_tracker_top_test.sv =====
// Self-checking testbench for diagonal_offset_vote_tracker_top: random reads of seed hits,
// a scoreboard that predicts every vote and read summary. Depends on dovt_pkg and dovt_if.
`timescale 1ns / 1ps
module diagonal_offset_vote_tracker_top_test;
  import dovt_pkg::*;

  localparam int IDLE_LIMIT   = 400000;
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    bit        action;
    bit [15:0] tid;
    bit [23:0] tp;
    bit [19:0] sp;
    bit [1:0]  side;
  } hit_item_t;

  typedef struct packed {
    bit [15:0] hit_votes;
    bit [15:0] top_votes;
    bit [15:0] best_tx;
    bit        best_valid;
    bit [15:0] runner_votes;
    bit        any_hit;
  } summary_t;

  typedef struct {
    int        epoch;
    int        best;
    int        second;
    bit [25:0] best_off;
    bit        used[Slots];
    bit [25:0] off[Slots];
    int        cnt[Slots];
    bit [1:0]  side[Slots];
  } tx_votes_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [4:0] cfg_wdata;

  dovt_in_if  in_bus();
  dovt_out_if out_bus();

  diagonal_offset_vote_tracker_top uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_bus), .out_ch(out_bus)
  );

  hit_item_t pending_hits[$];
  summary_t  expected_summaries[$];
  tx_votes_t tx_table[int];

  // predictor state
  bit [4:0] pred_shift;
  int       read_epoch = 1;
  int       gl_best = 0;
  int       gl_best_tx = 0;
  bit       gl_valid = 0;
  int       gl_runner = 0;
  bit       gl_any = 0;

  int  errors = 0;
  int  idle_cycles;
  int  cycle_count;
  bit  in_taken;
  int  burst_left;
  int  gap_left;
  int  stall_mode;

  function automatic bit [25:0] binned_diag(bit [23:0] tp, bit [19:0] sp, bit [4:0] sh);
    longint d;
    d = longint'(tp) - longint'(sp);
    return 26'(d >>> sh);
  endfunction

  function automatic summary_t predict_vote(hit_item_t it);
    summary_t  r;
    tx_votes_t e;
    bit [25:0] off;
    int        votes;
    int        pick;
    bit        found;
    votes = 0;
    if (it.action == ActNewRead) begin
      read_epoch = (read_epoch + 1) & 16'hFFFF;
      if (read_epoch == 0) begin
        read_epoch = 1;
        tx_table.delete();
      end
      gl_best = 0; gl_best_tx = 0; gl_valid = 0; gl_runner = 0; gl_any = 0;
    end else begin
      off = binned_diag(it.tp, it.sp, pred_shift);
      gl_any = 1;
      if (tx_table.exists(it.tid) && tx_table[it.tid].epoch == read_epoch) begin
        e = tx_table[it.tid];
      end else begin
        e.epoch = read_epoch; e.best = 0; e.second = 0; e.best_off = '0;
        for (int i = 0; i < Slots; i++) begin
          e.used[i] = 0; e.off[i] = '0; e.cnt[i] = 0; e.side[i] = '0;
        end
      end
      found = 0;
      for (int i = 0; i < Slots; i++) begin
        if (!found && e.used[i] && e.off[i] == off) begin
          found = 1;
          if (e.cnt[i] < 65535) e.cnt[i]++;
          e.side[i] |= it.side;
          votes = e.cnt[i];
        end
      end
      if (!found) begin
        pick = -1;
        for (int i = 0; i < Slots; i++)
          if (pick < 0 && !e.used[i]) pick = i;
        if (pick < 0) begin
          pick = 0;
          for (int i = 1; i < Slots; i++)
            if (e.cnt[i] < e.cnt[pick]) pick = i;
        end
        e.used[pick] = 1; e.off[pick] = off; e.cnt[pick] = 1; e.side[pick] = it.side;
        votes = 1;
      end
      if (votes >= e.best) begin
        if (off != e.best_off) e.second = e.best;
        e.best = votes;
        e.best_off = off;
      end else if (votes > e.second) begin
        e.second = votes;
      end
      tx_table[it.tid] = e;
      if (e.best == votes) begin
        if (votes > gl_best) begin
          gl_best = votes; gl_best_tx = it.tid; gl_valid = 1; gl_runner = e.second;
        end else if (gl_valid && it.tid == gl_best_tx) begin
          gl_runner = e.second;
        end
      end
    end
    r.hit_votes    = votes[15:0];
    r.top_votes    = gl_best[15:0];
    r.best_tx      = gl_valid ? gl_best_tx[15:0] : 16'd0;
    r.best_valid   = gl_valid;
    r.runner_votes = gl_runner[15:0];
    r.any_hit      = gl_any;
    return r;
  endfunction

  task automatic queue_hit(bit act, bit [15:0] tid, bit [23:0] tp, bit [19:0] sp,
                           bit [1:0] side);
    hit_item_t it;
    it.action = act; it.tid = tid; it.tp = tp; it.sp = sp; it.side = side;
    pending_hits.insert(pending_hits.size(), it);
  endtask

  // One read: a new-read action, then hits, mostly on a few transcripts and diagonals.
  task automatic queue_read(int n_hits);
    bit [15:0] tids[4];
    bit [23:0] diags[3];
    bit [19:0] sp;
    foreach (tids[i])
      tids[i] = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
    foreach (diags[i]) diags[i] = 24'($urandom);
    queue_hit(ActNewRead, 16'($urandom), 24'($urandom), 20'($urandom), 2'($urandom));
    for (int k = 0; k < n_hits; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_hit(1'($urandom), 16'($urandom), 24'($urandom), 20'($urandom), 2'($urandom));
      end else begin
        sp = 20'($urandom);
        queue_hit(ActHit, tids[$urandom_range(0, 3)],
                  24'(sp + diags[$urandom_range(0, 2)] + $urandom_range(0, 3)),
                  sp, 2'($urandom));
      end
    end
  endtask

  task automatic drain_and_settle();
    while (pending_hits.size() != 0 || in_bus.valid) @(posedge clk);
    while (expected_summaries.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_shift(bit [4:0] sh);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= sh;
    @(negedge clk);
    cfg_we <= 1'b0;
    pred_shift = sh;
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    pred_shift = 5;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: field extremes, negative diagonals, replacement of the weakest slot
    queue_hit(ActHit, 16'd0, 24'd0, 20'hFFFFF, 2'd1);
    queue_hit(ActHit, 16'd0, 24'd0, 20'hFFFFF, 2'd2);
    queue_hit(ActHit, 16'hFFFF, 24'hFFFFFF, 20'd0, 2'd3);
    queue_hit(ActHit, 16'hFFFF, 24'hFFFFFF, 20'd0, 2'd0);
    for (int i = 0; i < 5; i++) queue_hit(ActHit, 16'd1, 24'(i * 4096), 20'd0, 2'(i));
    queue_hit(ActHit, 16'd1, 24'd4096, 20'd0, 2'd1);
    queue_hit(ActHit, 16'd1, 24'd0, 20'd0, 2'd2);
    queue_hit(ActNewRead, 16'd0, 24'd0, 20'd0, 2'd0);
    queue_hit(ActHit, 16'd1, 24'd100, 20'd50, 2'd1);
    queue_hit(ActNewRead, 16'hFFFF, 24'hFFFFFF, 20'hFFFFF, 2'd3);
    drain_and_settle();

    write_shift(5'd0);
    queue_read(12);
    queue_hit(ActHit, 16'd2, 24'd0, 20'hFFFFF, 2'd1);
    drain_and_settle();
    write_shift(5'd31);
    queue_read(12);
    drain_and_settle();
    write_shift(5'd16);
    queue_read(12);
    drain_and_settle();

    // random reads over a few settings
    for (int ph = 0; ph < 4; ph++) begin
      write_shift(5'($urandom_range(0, 16)));
      while (pending_hits.size() < 90) queue_read($urandom_range(4, 30));
      drain_and_settle();
    end

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // driver: bursts with gaps, advance only after a transaction
  always @(negedge clk) begin
    if (rst) begin
      in_bus.valid <= 1'b0;
      in_bus.action <= 1'b0;
      in_bus.transcript_id <= '0;
      in_bus.target_position <= '0;
      in_bus.seed_position <= '0;
      in_bus.side_flags <= '0;
      out_bus.ready <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (!in_bus.valid || in_taken) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_bus.valid <= 1'b0;
        end else if (pending_hits.size() != 0) begin
          in_bus.valid <= 1'b1;
          in_bus.action <= pending_hits[0].action;
          in_bus.transcript_id <= pending_hits[0].tid;
          in_bus.target_position <= pending_hits[0].tp;
          in_bus.seed_position <= pending_hits[0].sp;
          in_bus.side_flags <= pending_hits[0].side;
          void'(pending_hits.pop_front());
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(0, 40);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
      case (stall_mode)
        0: out_bus.ready <= 1'b1;
        1: out_bus.ready <= 1'($urandom_range(0, 1));
        default: out_bus.ready <= (cycle_count % 4) == 0;
      endcase
    end
  end

  // monitor, scoreboard and watchdog
  always @(posedge clk) begin
    summary_t got;
    summary_t want;
    in_taken <= !rst && in_bus.valid && in_bus.ready;
    if (rst) begin
      idle_cycles <= 0;
      cycle_count <= 0;
      stall_mode <= 0;
    end else begin
      cycle_count <= cycle_count + 1;
      if (cycle_count % 64 == 0) stall_mode <= $urandom_range(0, 2);
      if (in_bus.valid && in_bus.ready) begin
        expected_summaries.insert(expected_summaries.size(),
            predict_vote(hit_item_t'{in_bus.action, in_bus.transcript_id,
            in_bus.target_position, in_bus.seed_position, in_bus.side_flags}));
      end
      if (out_bus.valid && out_bus.ready) begin
        got = '{out_bus.hit_votes, out_bus.top_votes, out_bus.best_transcript,
                out_bus.best_valid, out_bus.runner_votes, out_bus.any_hit};
        if (expected_summaries.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS) $display("unexpected result transaction %p", got);
        end else begin
          want = expected_summaries.pop_front();
          if (got != want) begin
            errors++;
            if (errors <= MAX_REPORTS) $display("mismatch: expected %p actual %p", want, got);
          end
        end
      end
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end
endmodule
